### rtl/core/dhta_pkg.sv
// Package: types, constants and saturating helpers of the hit topology accumulator.
package dhta_pkg;

  // Detector geometry and accumulator width
  localparam int SIDE_FACES = 4;
  localparam int SIDE_ROWS  = 4;
  localparam int SUM_BITS   = 24;

  // Widths fixed by the item fields
  localparam int CntBits    = 8;
  localparam int EnBits     = 16;
  localparam int EOutBits   = 24;
  localparam int ExtBits    = (SUM_BITS > EOutBits) ? SUM_BITS : EOutBits;

  // Record numbering: tile totals, ribbon totals, top face, side faces, side rows
  localparam int RecTile    = 0;
  localparam int RecRibbon  = 1;
  localparam int RecTop     = 2;
  localparam int RecRow0    = RecTop + 1 + SIDE_FACES;
  localparam int NumRecords = RecRow0 + SIDE_ROWS;
  localparam int RecBits    = $clog2(NumRecords);

  // Kind sum banks and their sub-sums
  localparam int KindTileSums   = 0;
  localparam int KindRibbonSums = 1;
  localparam int SumClean       = 0;
  localparam int SumGhost       = 1;
  localparam int SumTrigger     = 2;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_TILE   = 2'd1,
    KIND_RIBBON = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]        hit_kind;
    logic [2:0]        face;
    logic [1:0]        side_row;
    logic              is_ghost;
    logic              has_veto;
    logic [EnBits-1:0] tile_energy;
    logic [EnBits-1:0] ribbon_energy_a;
    logic [EnBits-1:0] ribbon_energy_b;
    logic              last_hit;
  } hit_t;

  typedef struct packed {
    logic [3:0]          record;
    logic [CntBits-1:0]  hit_count;
    logic [CntBits-1:0]  veto_count;
    logic [EOutBits-1:0] energy_total;
    logic [EOutBits-1:0] energy_clean;
    logic [EOutBits-1:0] energy_ghost;
    logic [EOutBits-1:0] energy_trigger;
    logic [CntBits-1:0]  all_veto_count;
    logic [3:0]          sides_hit;
    logic [3:0]          sides_veto;
    logic                last_record;
  } rec_t;

  // One group of counts and energy, one per record
  typedef struct packed {
    logic [CntBits-1:0]  hits;
    logic [CntBits-1:0]  vetoes;
    logic [SUM_BITS-1:0] energy;
  } grp_t;

  // Whole event accumulator
  typedef struct packed {
    grp_t [NumRecords-1:0]            grp;
    logic [1:0][2:0][SUM_BITS-1:0]    ksum;
    logic [CntBits-1:0]               any_vetoes;
    logic [7:0]                       hit_mask;
    logic [7:0]                       veto_mask;
  } acc_t;

  // Count up, hold at full scale
  function automatic logic [CntBits-1:0] sat_inc(logic [CntBits-1:0] c);
    sat_inc = (c == {CntBits{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Add an energy, hold at full scale
  function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] s,
                                                  logic [EnBits-1:0] v);
    logic [SUM_BITS:0] t;
    t = {1'b0, s} + (SUM_BITS+1)'(v);
    sat_add = t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
  endfunction

  // Clamp a sum to the output field
  function automatic logic [EOutBits-1:0] out_e(logic [SUM_BITS-1:0] s);
    logic [ExtBits-1:0] ext;
    ext = ExtBits'(s);
    if (ext > ExtBits'({EOutBits{1'b1}})) begin
      out_e = {EOutBits{1'b1}};
    end else begin
      out_e = ext[EOutBits-1:0];
    end
  endfunction

endpackage

### rtl/core/detector_hit_topology_accumulator_unit.sv
// Hit topology accumulator: per-event counts and energy sums, drained as records.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one hit per cycle.
// Each accepted hit updates the event accumulators in the cycle of its transfer
// with saturating adds and counts. The hit marked last_hit is accumulated too,
// then the whole accumulator is copied into an output bank and cleared, so the
// next event starts at once.
// Output channel (out_valid_o / out_ready_i / out_data_o) shows the bank as
// NumRecords records (11 here), one per cycle, record 0 valid in the cycle
// after the last hit's transfer; last_record marks the final one.
// Throughput: one hit per cycle. A hit without last_hit is always taken. A
// last hit is held off only while an earlier event's bank still drains, until
// that event's final record transfers (in_ready_o then follows out_ready_i in
// the same cycle).
// Receiver stall: the current record holds; hits keep accumulating.
// Reset clears accumulators and the output bank valid flag at once.
module detector_hit_topology_accumulator_unit
  import dhta_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  hit_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rec_t out_data_o
);

  acc_t               acc_q, acc_d, acc_upd;
  acc_t               bank_q, bank_d;
  logic               busy_q, busy_d;
  logic [RecBits-1:0] rec_q, rec_d;

  logic               in_xfer, out_xfer, rec_last;
  logic               side;
  logic [EnBits:0]    rib_sum;
  logic [EnBits-1:0]  rib_e;

  assign rec_last    = (rec_q == RecBits'(NumRecords - 1));
  assign out_xfer    = busy_q && out_ready_i;
  assign in_ready_o  = !busy_q || !in_data_i.last_hit || (out_ready_i && rec_last);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = busy_q;

  // Ribbon energy: mean of the two readouts, truncated
  assign rib_sum = {1'b0, in_data_i.ribbon_energy_a} + {1'b0, in_data_i.ribbon_energy_b};
  assign rib_e   = rib_sum[EnBits:1];
  assign side    = (in_data_i.face != 3'd0) && (int'(in_data_i.face) <= SIDE_FACES);

  // Fold one hit into the accumulator
  always_comb begin
    acc_upd = acc_q;
    if (in_data_i.has_veto) begin
      acc_upd.any_vetoes = sat_inc(acc_q.any_vetoes);
    end
    if (in_data_i.hit_kind == KIND_TILE) begin
      acc_upd.grp[RecTile].hits   = sat_inc(acc_q.grp[RecTile].hits);
      acc_upd.grp[RecTile].energy = sat_add(acc_q.grp[RecTile].energy,
                                            in_data_i.tile_energy);
      acc_upd.hit_mask[in_data_i.face] = 1'b1;
      if (in_data_i.has_veto) begin
        acc_upd.veto_mask[in_data_i.face] = 1'b1;
        acc_upd.grp[RecTile].vetoes = sat_inc(acc_q.grp[RecTile].vetoes);
        acc_upd.ksum[KindTileSums][SumTrigger] =
          sat_add(acc_q.ksum[KindTileSums][SumTrigger], in_data_i.tile_energy);
      end
      if (in_data_i.is_ghost) begin
        acc_upd.ksum[KindTileSums][SumGhost] =
          sat_add(acc_q.ksum[KindTileSums][SumGhost], in_data_i.tile_energy);
      end else begin
        acc_upd.ksum[KindTileSums][SumClean] =
          sat_add(acc_q.ksum[KindTileSums][SumClean], in_data_i.tile_energy);
      end
      // Top and side faces
      for (int i = 0; i <= SIDE_FACES; i++) begin
        if (int'(in_data_i.face) == i) begin
          acc_upd.grp[RecTop+i].hits   = sat_inc(acc_q.grp[RecTop+i].hits);
          acc_upd.grp[RecTop+i].energy = sat_add(acc_q.grp[RecTop+i].energy,
                                                 in_data_i.tile_energy);
          if (in_data_i.has_veto) begin
            acc_upd.grp[RecTop+i].vetoes = sat_inc(acc_q.grp[RecTop+i].vetoes);
          end
        end
      end
      // Side rows, side faces only
      for (int j = 0; j < SIDE_ROWS; j++) begin
        if (side && int'(in_data_i.side_row) == j) begin
          acc_upd.grp[RecRow0+j].hits   = sat_inc(acc_q.grp[RecRow0+j].hits);
          acc_upd.grp[RecRow0+j].energy = sat_add(acc_q.grp[RecRow0+j].energy,
                                                  in_data_i.tile_energy);
          if (in_data_i.has_veto) begin
            acc_upd.grp[RecRow0+j].vetoes = sat_inc(acc_q.grp[RecRow0+j].vetoes);
          end
        end
      end
    end else if (in_data_i.hit_kind == KIND_RIBBON) begin
      acc_upd.grp[RecRibbon].hits   = sat_inc(acc_q.grp[RecRibbon].hits);
      acc_upd.grp[RecRibbon].energy = sat_add(acc_q.grp[RecRibbon].energy, rib_e);
      if (in_data_i.has_veto) begin
        acc_upd.ksum[KindRibbonSums][SumTrigger] =
          sat_add(acc_q.ksum[KindRibbonSums][SumTrigger], rib_e);
      end
      if (in_data_i.is_ghost) begin
        acc_upd.ksum[KindRibbonSums][SumGhost] =
          sat_add(acc_q.ksum[KindRibbonSums][SumGhost], rib_e);
      end else begin
        acc_upd.ksum[KindRibbonSums][SumClean] =
          sat_add(acc_q.ksum[KindRibbonSums][SumClean], rib_e);
      end
    end
  end

  // Advance accumulator, bank and record pointer
  always_comb begin
    acc_d  = acc_q;
    bank_d = bank_q;
    busy_d = busy_q;
    rec_d  = rec_q;
    if (out_xfer) begin
      if (rec_last) begin
        busy_d = 1'b0;
        rec_d  = '0;
      end else begin
        rec_d = rec_q + 1'b1;
      end
    end
    if (in_xfer) begin
      if (in_data_i.last_hit) begin
        bank_d = acc_upd;
        acc_d  = '0;
        busy_d = 1'b1;
        rec_d  = '0;
      end else begin
        acc_d = acc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      busy_q <= 1'b0;
      rec_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      busy_q <= busy_d;
      rec_q  <= rec_d;
    end
  end

  // Bank is payload only
  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
  end

  // Select the current record from the bank
  always_comb begin
    out_data_o              = '0;
    out_data_o.record       = 4'(rec_q);
    out_data_o.hit_count    = bank_q.grp[rec_q].hits;
    out_data_o.veto_count   = bank_q.grp[rec_q].vetoes;
    out_data_o.energy_total = out_e(bank_q.grp[rec_q].energy);
    out_data_o.last_record  = rec_last;
    if (rec_q == RecBits'(RecTile)) begin
      out_data_o.energy_clean   = out_e(bank_q.ksum[KindTileSums][SumClean]);
      out_data_o.energy_ghost   = out_e(bank_q.ksum[KindTileSums][SumGhost]);
      out_data_o.energy_trigger = out_e(bank_q.ksum[KindTileSums][SumTrigger]);
      out_data_o.all_veto_count = bank_q.any_vetoes;
      out_data_o.sides_hit      = 4'($countones(bank_q.hit_mask));
      out_data_o.sides_veto     = 4'($countones(bank_q.veto_mask));
    end else if (rec_q == RecBits'(RecRibbon)) begin
      out_data_o.energy_clean   = out_e(bank_q.ksum[KindRibbonSums][SumClean]);
      out_data_o.energy_ghost   = out_e(bank_q.ksum[KindRibbonSums][SumGhost]);
      out_data_o.energy_trigger = out_e(bank_q.ksum[KindRibbonSums][SumTrigger]);
    end
  end

endmodule

### rtl/core/dhta_checker.sv
// Checker: port-level assertions on the hit topology accumulator, with its bind.
module dhta_checker
  import dhta_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input hit_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rec_t out_data_o
);

  // Stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("record changed while stalled");

  // Records of one event follow in order
  a_rec_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_record
    |=> out_valid_o && (out_data_o.record == 4'($past(out_data_o.record) + 4'd1)))
    else $error("record sequence broken");

  // A last hit opens an event drain at record 0
  a_last_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_hit
    |=> out_valid_o && (out_data_o.record == 4'd0))
    else $error("event drain did not start at record 0");

  // Event-wide fields only on the tile totals record
  a_tile_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.record != 4'd0)
    |-> (out_data_o.all_veto_count == '0) && (out_data_o.sides_hit == 4'd0)
        && (out_data_o.sides_veto == 4'd0))
    else $error("event-wide field set outside record 0");

endmodule

bind detector_hit_topology_accumulator_unit dhta_checker u_dhta_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

### sim/testbench.sv
// Self-checking testbench for the detector hit topology accumulator.
`timescale 1ns / 100ps

module testbench;
  import dhta_pkg::*;

  localparam int          CycleLimit = 100000;
  localparam logic [1:0]  KindUnused = 2'd3;
  localparam logic [15:0] EnFull     = 16'hFFFF;

  typedef enum int {MixShort, TileFlood} hit_mix_e;

  // Event tally predictor and the queue of records it expects
  class event_tally_board;
    logic [CntBits-1:0]  tile_cnt, ribbon_cnt, veto_all_cnt, tile_veto_cnt;
    logic [SUM_BITS-1:0] kind_sum [2][4];   // bank, then total/clean/ghost/trigger
    logic [CntBits-1:0]  face_cnt [SIDE_FACES+1];
    logic [CntBits-1:0]  face_veto_cnt [SIDE_FACES+1];
    logic [SUM_BITS-1:0] face_sum [SIDE_FACES+1];
    logic [CntBits-1:0]  row_cnt [SIDE_ROWS];
    logic [CntBits-1:0]  row_veto_cnt [SIDE_ROWS];
    logic [SUM_BITS-1:0] row_sum [SIDE_ROWS];
    logic [7:0]          face_hit_bits, face_veto_bits;
    rec_t                records_due [$];
    int                  errors;

    function new();
      errors = 0;
      clear_event();
    endfunction

    function void clear_event();
      tile_cnt = '0;
      ribbon_cnt = '0;
      veto_all_cnt = '0;
      tile_veto_cnt = '0;
      face_hit_bits = '0;
      face_veto_bits = '0;
      foreach (kind_sum[b, s]) kind_sum[b][s] = '0;
      foreach (face_cnt[i]) begin
        face_cnt[i] = '0;
        face_veto_cnt[i] = '0;
        face_sum[i] = '0;
      end
      foreach (row_cnt[i]) begin
        row_cnt[i] = '0;
        row_veto_cnt[i] = '0;
        row_sum[i] = '0;
      end
    endfunction

    // Count up, hold at full scale
    function logic [CntBits-1:0] bump(logic [CntBits-1:0] c);
      return (c == {CntBits{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Add energy, hold at the top of the sum width
    function logic [SUM_BITS-1:0] add_energy(logic [SUM_BITS-1:0] s, logic [16:0] v);
      logic [63:0] t;
      logic [63:0] top;
      top = (64'd1 << SUM_BITS) - 64'd1;
      t = 64'(s) + 64'(v);
      if (t > top) t = top;
      return t[SUM_BITS-1:0];
    endfunction

    // Clamp a sum to the output field
    function logic [EOutBits-1:0] clamp_out(logic [SUM_BITS-1:0] s);
      logic [63:0] w;
      w = 64'(s);
      return (w > 64'hFFFFFF) ? 24'hFFFFFF : w[23:0];
    endfunction

    function void add_kind(int bank, logic [16:0] e, logic ghost, logic veto);
      kind_sum[bank][0] = add_energy(kind_sum[bank][0], e);
      if (!ghost) kind_sum[bank][1] = add_energy(kind_sum[bank][1], e);
      if (ghost) kind_sum[bank][2] = add_energy(kind_sum[bank][2], e);
      if (veto) kind_sum[bank][3] = add_energy(kind_sum[bank][3], e);
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    // Fold an accepted hit into the tally; on the last hit queue the records
    function void take_hit(hit_t h);
      logic        side;
      logic [16:0] rib_e;
      rec_t        r;
      int          f;
      if (h.has_veto) veto_all_cnt = bump(veto_all_cnt);
      f = int'(h.face);
      case (h.hit_kind)
        KIND_TILE: begin
          side = (f >= 1) && (f <= SIDE_FACES);
          tile_cnt = bump(tile_cnt);
          face_hit_bits[f] = 1'b1;
          if (h.has_veto) begin
            face_veto_bits[f] = 1'b1;
            tile_veto_cnt = bump(tile_veto_cnt);
          end
          add_kind(0, 17'(h.tile_energy), h.is_ghost, h.has_veto);
          if (f == 0 || side) begin
            face_cnt[f] = bump(face_cnt[f]);
            if (h.has_veto) face_veto_cnt[f] = bump(face_veto_cnt[f]);
            face_sum[f] = add_energy(face_sum[f], 17'(h.tile_energy));
          end
          if (side && int'(h.side_row) < SIDE_ROWS) begin
            row_cnt[h.side_row] = bump(row_cnt[h.side_row]);
            if (h.has_veto) row_veto_cnt[h.side_row] = bump(row_veto_cnt[h.side_row]);
            row_sum[h.side_row] = add_energy(row_sum[h.side_row], 17'(h.tile_energy));
          end
        end
        KIND_RIBBON: begin
          ribbon_cnt = bump(ribbon_cnt);
          rib_e = (17'(h.ribbon_energy_a) + 17'(h.ribbon_energy_b)) >> 1;
          add_kind(1, rib_e, h.is_ghost, h.has_veto);
        end
        default: ;
      endcase
      if (!h.last_hit) return;

      // Tile totals
      r = '0;
      r.record = 4'(RecTile);
      r.hit_count = tile_cnt;
      r.veto_count = tile_veto_cnt;
      r.energy_total = clamp_out(kind_sum[0][0]);
      r.energy_clean = clamp_out(kind_sum[0][1]);
      r.energy_ghost = clamp_out(kind_sum[0][2]);
      r.energy_trigger = clamp_out(kind_sum[0][3]);
      r.all_veto_count = veto_all_cnt;
      r.sides_hit = 4'($countones(face_hit_bits));
      r.sides_veto = 4'($countones(face_veto_bits));
      records_due.push_back(r);
      // Ribbon totals
      r = '0;
      r.record = 4'(RecRibbon);
      r.hit_count = ribbon_cnt;
      r.energy_total = clamp_out(kind_sum[1][0]);
      r.energy_clean = clamp_out(kind_sum[1][1]);
      r.energy_ghost = clamp_out(kind_sum[1][2]);
      r.energy_trigger = clamp_out(kind_sum[1][3]);
      records_due.push_back(r);
      // Top face, then side faces
      for (int i = 0; i <= SIDE_FACES; i++) begin
        r = '0;
        r.record = 4'(RecTop + i);
        r.hit_count = face_cnt[i];
        r.veto_count = face_veto_cnt[i];
        r.energy_total = clamp_out(face_sum[i]);
        records_due.push_back(r);
      end
      // Side rows; the final one closes the event
      for (int i = 0; i < SIDE_ROWS; i++) begin
        r = '0;
        r.record = 4'(RecRow0 + i);
        r.hit_count = row_cnt[i];
        r.veto_count = row_veto_cnt[i];
        r.energy_total = clamp_out(row_sum[i]);
        r.last_record = (i == SIDE_ROWS - 1);
        records_due.push_back(r);
      end
      clear_event();
    endfunction

    function void compare(string what, int rec, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t: record %0d %s expected %0h actual %0h", $time, rec, what, want, seen);
        errors++;
      end
    endfunction

    // Compare a transferred record with the oldest one due
    function void check_record(rec_t got);
      rec_t want;
      int   rec;
      if (records_due.size() == 0) begin
        $display("%0t: record %0d arrived with none expected, expected nothing actual %0h",
                 $time, got.record, got);
        errors++;
        return;
      end
      want = records_due.pop_front();
      rec = int'(want.record);
      compare("record", rec, 64'(want.record), 64'(got.record));
      compare("hit_count", rec, 64'(want.hit_count), 64'(got.hit_count));
      compare("veto_count", rec, 64'(want.veto_count), 64'(got.veto_count));
      compare("energy_total", rec, 64'(want.energy_total), 64'(got.energy_total));
      compare("energy_clean", rec, 64'(want.energy_clean), 64'(got.energy_clean));
      compare("energy_ghost", rec, 64'(want.energy_ghost), 64'(got.energy_ghost));
      compare("energy_trigger", rec, 64'(want.energy_trigger), 64'(got.energy_trigger));
      compare("all_veto_count", rec, 64'(want.all_veto_count), 64'(got.all_veto_count));
      compare("sides_hit", rec, 64'(want.sides_hit), 64'(got.sides_hit));
      compare("sides_veto", rec, 64'(want.sides_veto), 64'(got.sides_veto));
      compare("last_record", rec, 64'(want.last_record), 64'(got.last_record));
    endfunction
  endclass

  logic clk;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hit_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rec_t out_data;

  event_tally_board board = new();
  bit   steady = 1'b0;    // no idling on either side while set
  bit   hold_req = 1'b0;  // ask the receiver for a long hold-off
  int   cycles = 0;

  detector_hit_topology_accumulator_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic hit_t mk_hit(logic [1:0] kind, int face, int row, bit ghost, bit veto,
                                  logic [15:0] te, logic [15:0] ra, logic [15:0] rb,
                                  bit last);
    hit_t h;
    h.hit_kind = kind;
    h.face = 3'(face);
    h.side_row = 2'(row);
    h.is_ghost = ghost;
    h.has_veto = veto;
    h.tile_energy = te;
    h.ribbon_energy_a = ra;
    h.ribbon_energy_b = rb;
    h.last_hit = last;
    return h;
  endfunction

  function automatic logic [15:0] rand_energy();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return EnFull;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic bit want_gap();
    return !steady && ($urandom_range(99) < 16);
  endfunction

  // Random hit content; the flood mix piles up on one group to reach saturation
  function automatic hit_t rand_hit(hit_mix_e mix);
    hit_t h;
    int   pick;
    h.hit_kind = 2'($urandom_range(3));
    h.face = 3'($urandom_range(7));
    h.side_row = 2'($urandom_range(3));
    h.is_ghost = 1'($urandom_range(1));
    h.has_veto = 1'($urandom_range(1));
    h.tile_energy = rand_energy();
    h.ribbon_energy_a = rand_energy();
    h.ribbon_energy_b = rand_energy();
    h.last_hit = 1'b0;
    pick = $urandom_range(99);
    case (mix)
      MixShort: begin
        if (pick < 50) h.hit_kind = KIND_TILE;
        else if (pick < 80) h.hit_kind = KIND_RIBBON;
        else if (pick < 90) h.hit_kind = KIND_NONE;
        else h.hit_kind = KindUnused;
        if ($urandom_range(99) < 70) h.face = 3'($urandom_range(SIDE_FACES));
      end
      TileFlood: begin
        if (pick < 98) begin
          h.hit_kind = KIND_TILE;
          h.face = 3'd1;
          h.side_row = 2'd0;
          h.has_veto = 1'b1;
          h.is_ghost = ($urandom_range(99) < 5);
          h.tile_energy = 16'($urandom_range(65535, 64000));
        end
      end
      default: ;
    endcase
    return h;
  endfunction

  // Offer one hit, hold it until the transfer, then note it
  task automatic send_hit(hit_t h);
    while (want_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_hit(h);
  endtask

  task automatic send_event(hit_mix_e mix, int len);
    hit_t h;
    for (int i = 0; i < len; i++) begin
      h = rand_hit(mix);
      h.last_hit = (i == len - 1);
      send_hit(h);
    end
  endtask

  // Receiver: check each transfer, then pick next cycle's ready
  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_record(out_data);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // Stimulus
  initial begin
    hit_t script [$];
    int   n_short;
    int   len;
    n_short = 0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: every face, kind and flag, energy extremes, ribbon truncation
    script.push_back(mk_hit(KIND_TILE, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0));
    script.push_back(mk_hit(KIND_TILE, 1, 3, 1, 1, EnFull, EnFull, EnFull, 0));
    script.push_back(mk_hit(KIND_TILE, 2, 1, 0, 1, 16'h0001, 16'h0000, EnFull, 0));
    script.push_back(mk_hit(KIND_TILE, 3, 2, 1, 0, 16'h8000, 16'h5555, 16'hAAAA, 0));
    script.push_back(mk_hit(KIND_TILE, 4, 0, 0, 1, EnFull, 16'h0000, 16'h0000, 0));
    script.push_back(mk_hit(KIND_TILE, 5, 1, 0, 1, 16'h1234, 16'h0000, 16'h0000, 0));
    script.push_back(mk_hit(KIND_TILE, 6, 3, 1, 0, 16'h00FF, 16'h0000, 16'h0000, 0));
    script.push_back(mk_hit(KIND_TILE, 7, 2, 1, 1, EnFull, EnFull, EnFull, 0));
    script.push_back(mk_hit(KIND_RIBBON, 0, 0, 1, 1, 16'h0000, EnFull, EnFull, 0));
    script.push_back(mk_hit(KIND_RIBBON, 7, 3, 0, 0, EnFull, EnFull, 16'h0000, 0));
    script.push_back(mk_hit(KIND_RIBBON, 2, 1, 0, 1, 16'h0000, 16'h0001, 16'h0000, 0));
    script.push_back(mk_hit(KIND_NONE, 1, 1, 0, 1, EnFull, EnFull, EnFull, 0));
    script.push_back(mk_hit(KindUnused, 1, 2, 1, 1, EnFull, EnFull, EnFull, 0));
    script.push_back(mk_hit(KIND_TILE, 1, 0, 0, 0, 16'h7FFF, 16'h0000, 16'h0000, 1));
    script.push_back(mk_hit(KIND_NONE, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 1));
    script.push_back(mk_hit(KIND_RIBBON, 4, 2, 1, 0, 16'h0000, 16'h0003, 16'h0000, 1));
    script.push_back(mk_hit(KIND_TILE, 3, 3, 0, 1, 16'hFFFE, 16'h0000, 16'h0000, 1));
    script.push_back(mk_hit(KindUnused, 6, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 1));
    foreach (script[i]) send_hit(script[i]);

    // Saturate the tile counts and sums with no idling, then short events under a hold-off
    steady = 1'b1;
    send_event(TileFlood, 270);
    steady = 1'b0;
    hold_req = 1'b1;
    while (n_short < 36) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 30);
      send_event(MixShort, len);
      n_short += len;
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
